@@ src/pl0lex_pkg.sv @@
`timescale 1ns / 1ps
package pl0lex_pkg;

	localparam int MAX_NAME_LEN = 16;
	localparam int VALUE_BITS   = 32;
	localparam int NAME_CNT_W   = $clog2(MAX_NAME_LEN + 1);

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_COLON   = 3'd1;
	localparam logic [2:0] MODE_LESS    = 3'd2;
	localparam logic [2:0] MODE_GREATER = 3'd3;
	localparam logic [2:0] MODE_NAME    = 3'd4;
	localparam logic [2:0] MODE_NUMBER  = 3'd5;

	localparam logic [5:0] TK_COLON   = 6'd0;
	localparam logic [5:0] TK_BECOMES = 6'd1;
	localparam logic [5:0] TK_COMMA   = 6'd2;
	localparam logic [5:0] TK_DOT     = 6'd3;
	localparam logic [5:0] TK_LPAREN  = 6'd4;
	localparam logic [5:0] TK_RPAREN  = 6'd5;
	localparam logic [5:0] TK_SEMI    = 6'd6;
	localparam logic [5:0] TK_TIMES   = 6'd7;
	localparam logic [5:0] TK_SLASH   = 6'd8;
	localparam logic [5:0] TK_PLUS    = 6'd9;
	localparam logic [5:0] TK_MINUS   = 6'd10;
	localparam logic [5:0] TK_EQ      = 6'd11;
	localparam logic [5:0] TK_NEQ     = 6'd12;
	localparam logic [5:0] TK_LEQ     = 6'd13;
	localparam logic [5:0] TK_LSS     = 6'd14;
	localparam logic [5:0] TK_GEQ     = 6'd15;
	localparam logic [5:0] TK_GTR     = 6'd16;
	localparam logic [5:0] TK_KW_BASE = 6'd17;
	localparam logic [5:0] TK_IDENT   = 6'd31;
	localparam logic [5:0] TK_NUMBER  = 6'd32;

	localparam int NUM_KW = 14;
	// keywords packed first char in low byte, with lengths
	localparam logic [8*9-1:0] KW_TEXT [NUM_KW] = '{
		72'h656c75646f6d, 72'h6572756465636f7270, 72'h6e69676562, 72'h646e65,
		72'h74736e6f63, 72'h726176, 72'h746e69, 72'h6669,
		72'h6e656874, 72'h656c696877, 72'h6f64, 72'h7475706e69,
		72'h74757074756f, 72'h64646f
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd6, 4'd9, 4'd5, 4'd3, 4'd5, 4'd3, 4'd3, 4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd6, 4'd3
	};

	typedef struct packed {
		logic [5:0]              kind;
		logic [VALUE_BITS-1:0]   value;
		logic                    sat;
		logic [63:0]             lo;
		logic [63:0]             hi;
		logic [4:0]              len;
		logic                    trunc;
	} token_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

endpackage

@@ src/pl0lex_scan.sv @@
`timescale 1ns / 1ps
module pl0lex_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [7:0]                 c,
	input  logic                       eot,
	output logic [1:0]                 n_tok,
	output pl0lex_pkg::token_t         tok0,
	output pl0lex_pkg::token_t         tok1
);
	import pl0lex_pkg::*;

	logic [2:0]                mode_q, mode_d;
	logic [7:0]                name_q [MAX_NAME_LEN];
	logic [NAME_CNT_W-1:0]     cnt_q, cnt_d;
	logic                      ovf_q, ovf_d;
	logic [VALUE_BITS-1:0]     acc_q, acc_d;
	logic                      nsat_q, nsat_d;
	logic                      wr_en;
	logic [NAME_CNT_W-1:0]     wr_idx;
	logic [VALUE_BITS+3:0]     mul10;
	logic [VALUE_BITS-1:0]     acc_next;
	logic                      acc_ovf;
	logic                      num_ext;
	logic                      name_ext, name_add;
	logic [NAME_CNT_W-1:0]     cnt_v;
	logic                      ovf_v;
	token_t                    pend_tok, simple_tok, fresh_tok;
	logic                      pend_has, fresh_has, fresh_out;
	logic [63:0]               lo, hi;
	logic [MAX_NAME_LEN*8-1:0] flat;
	logic                      kw_hit;
	logic [5:0]                kw_kind;
	logic                      used;
	logic [2:0]                fresh_mode;

	// accumulate decimal digit with clamp
	always_comb begin
		mul10 = {4'd0, acc_q} * (VALUE_BITS+4)'(10) + (VALUE_BITS+4)'(c - 8'h30);
		acc_ovf = |mul10[VALUE_BITS+3:VALUE_BITS];
		acc_next = acc_ovf ? '1 : mul10[VALUE_BITS-1:0];
		num_ext = mode_q == MODE_NUMBER && is_digit(c);
	end

	// keyword match and identifier packing, name as it stands after this byte
	always_comb begin
		name_ext = mode_q == MODE_NAME && (is_letter(c) || is_digit(c));
		name_add = name_ext && int'(cnt_q) < MAX_NAME_LEN;
		cnt_v = cnt_q + NAME_CNT_W'(name_add);
		ovf_v = ovf_q || (name_ext && !name_add);
		for (int i = 0; i < MAX_NAME_LEN; i++)
			flat[i*8 +: 8] = (i < int'(cnt_q)) ? name_q[i] :
				(name_add && i == int'(cnt_q)) ? c : 8'd0;
		lo = flat[63:0];
		hi = 64'(flat[MAX_NAME_LEN*8-1:64]);
		kw_hit = 1'b0;
		kw_kind = TK_IDENT;
		for (int k = 0; k < NUM_KW; k++)
			if (!ovf_v && cnt_v == NAME_CNT_W'(KW_LEN[k])
				&& flat[71:0] == KW_TEXT[k]) begin
				kw_hit = 1'b1;
				kw_kind = TK_KW_BASE + 6'(k);
			end
	end

	// token closed by flushing the pending state
	always_comb begin
		pend_tok = '0;
		pend_has = 1'b1;
		case (mode_q)
			MODE_COLON:   pend_tok.kind = TK_COLON;
			MODE_LESS:    pend_tok.kind = TK_LSS;
			MODE_GREATER: pend_tok.kind = TK_GTR;
			MODE_NUMBER: begin
				pend_tok.kind = TK_NUMBER;
				pend_tok.value = num_ext ? acc_next : acc_q;
				pend_tok.sat = nsat_q | (num_ext & acc_ovf);
			end
			MODE_NAME: begin
				pend_tok.kind = kw_kind;
				if (!kw_hit) begin
					pend_tok.lo = lo;
					pend_tok.hi = hi;
					pend_tok.len = 5'(cnt_v);
					pend_tok.trunc = ovf_v;
				end
			end
			default: pend_has = 1'b0;
		endcase
	end

	always_comb begin
		simple_tok = '0;
		used = 1'b0;
		case (mode_q)
			MODE_COLON: begin
				used = c == 8'h3d;
				simple_tok.kind = TK_BECOMES;
			end
			MODE_LESS: begin
				used = c == 8'h3e || c == 8'h3d;
				simple_tok.kind = (c == 8'h3e) ? TK_NEQ : TK_LEQ;
			end
			MODE_GREATER: begin
				used = c == 8'h3d;
				simple_tok.kind = TK_GEQ;
			end
			MODE_NAME:   used = is_letter(c) || is_digit(c);
			MODE_NUMBER: used = is_digit(c);
			default:     used = 1'b0;
		endcase
	end

	// token started by this byte; for a pending start it is the token end_of_text flushes
	always_comb begin
		fresh_tok = '0;
		fresh_has = 1'b1;
		fresh_mode = MODE_IDLE;
		case (c)
			8'h3a: begin
				fresh_has = 1'b0; fresh_mode = MODE_COLON; fresh_tok.kind = TK_COLON;
			end
			8'h3c: begin
				fresh_has = 1'b0; fresh_mode = MODE_LESS; fresh_tok.kind = TK_LSS;
			end
			8'h3e: begin
				fresh_has = 1'b0; fresh_mode = MODE_GREATER; fresh_tok.kind = TK_GTR;
			end
			8'h2c: fresh_tok.kind = TK_COMMA;
			8'h2e: fresh_tok.kind = TK_DOT;
			8'h28: fresh_tok.kind = TK_LPAREN;
			8'h29: fresh_tok.kind = TK_RPAREN;
			8'h3b: fresh_tok.kind = TK_SEMI;
			8'h2a: fresh_tok.kind = TK_TIMES;
			8'h2f: fresh_tok.kind = TK_SLASH;
			8'h2b: fresh_tok.kind = TK_PLUS;
			8'h2d: fresh_tok.kind = TK_MINUS;
			8'h3d: fresh_tok.kind = TK_EQ;
			default: begin
				fresh_has = 1'b0;
				if (is_letter(c)) begin
					fresh_mode = MODE_NAME;
					fresh_tok.kind = TK_IDENT;
					fresh_tok.lo = 64'(c);
					fresh_tok.len = 5'd1;
				end else if (is_digit(c)) begin
					fresh_mode = MODE_NUMBER;
					fresh_tok.kind = TK_NUMBER;
					fresh_tok.value = VALUE_BITS'(c - 8'h30);
				end
			end
		endcase
		fresh_out = fresh_has || (eot && fresh_mode != MODE_IDLE);
	end

	// result selection and next state
	always_comb begin
		n_tok = 2'd0;
		tok0 = pend_tok;
		tok1 = fresh_tok;
		mode_d = mode_q;
		cnt_d = cnt_q;
		ovf_d = ovf_q;
		acc_d = acc_q;
		nsat_d = nsat_q;
		wr_en = 1'b0;
		wr_idx = cnt_q;
		if (used) begin
			if (mode_q == MODE_NAME) begin
				wr_en = name_add;
				cnt_d = cnt_v;
				ovf_d = ovf_v;
			end else if (mode_q == MODE_NUMBER) begin
				acc_d = acc_next;
				nsat_d = nsat_q | acc_ovf;
			end else begin
				tok0 = simple_tok;
				n_tok = 2'd1;
				mode_d = MODE_IDLE;
			end
			if (eot && (mode_q == MODE_NAME || mode_q == MODE_NUMBER)) begin
				// flush the token just extended by this byte
				n_tok = 2'd1;
				mode_d = MODE_IDLE;
			end
		end else begin
			if (pend_has) n_tok = 2'd1;
			if (fresh_out) begin
				if (!pend_has) tok0 = fresh_tok;
				n_tok = n_tok + 2'd1;
			end
			mode_d = eot ? MODE_IDLE : fresh_mode;
			ovf_d = 1'b0;
			nsat_d = 1'b0;
			acc_d = '0;
			cnt_d = '0;
			wr_idx = '0;
			if (fresh_mode == MODE_NAME) begin
				wr_en = 1'b1;
				cnt_d = NAME_CNT_W'(1);
			end else if (fresh_mode == MODE_NUMBER) begin
				acc_d = VALUE_BITS'(c - 8'h30);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			acc_q <= '0;
			nsat_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			cnt_q <= (mode_d == MODE_IDLE) ? '0 : cnt_d;
			ovf_q <= (mode_d == MODE_IDLE) ? 1'b0 : ovf_d;
			acc_q <= (mode_d == MODE_IDLE) ? '0 : acc_d;
			nsat_q <= (mode_d == MODE_IDLE) ? 1'b0 : nsat_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en)
			name_q[wr_idx[$clog2(MAX_NAME_LEN)-1:0]] <= c;
	end

endmodule

@@ src/pl0_lexer_token_scanner_top.sv @@
`timescale 1ns / 1ps
// pl0 token scanner
// input channel: one source byte per word (char_in) with end_of_text on the last
// byte of the text; in_valid/in_stall handshake, accepted when valid and not stall
// output channel: one token per word, out_valid/out_stall handshake
// each byte yields zero, one or two tokens (a closed pending token, then a new one,
// or a token flushed by end_of_text); last_of_run marks the final token of a byte
// the first token of a byte is registered in the result slot when the byte is accepted
// throughput: one byte per cycle while it yields at most one token and out_stall is low;
// a byte yielding two tokens holds the input while the second token drains
// names keep up to 16 characters; integers clamp at 2^32-1 and flag saturation
// reset clears the pending token, the counters and the output register
// when the receiver stalls the output word holds, and the input stalls while a word
// waits in the result register under stall or a second token waits behind it
module pl0_lexer_token_scanner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [31:0] int_value,
	output logic        int_saturated,
	output logic [63:0] id_chars_low,
	output logic [63:0] id_chars_high,
	output logic [4:0]  id_length,
	output logic        id_truncated,
	output logic        last_of_run
);
	import pl0lex_pkg::*;

	logic [1:0] n_tok;
	token_t     tok0, tok1;
	logic       step;
	// result slot plus one extra slot for the second token of a byte
	token_t     res_q, extra_q;
	logic       res_v_q, extra_v_q, res_last_q;
	logic       out_take;

	pl0lex_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.c      (char_in),
		.eot    (end_of_text),
		.n_tok  (n_tok),
		.tok0   (tok0),
		.tok1   (tok1)
	);

	assign out_take = res_v_q && !out_stall;
	// accept a byte when both slots will be free after this edge
	assign in_stall = extra_v_q || (res_v_q && out_stall);
	assign step = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			extra_q <= '0;
			res_v_q <= 1'b0;
			extra_v_q <= 1'b0;
			res_last_q <= 1'b0;
		end else if (extra_v_q) begin
			if (out_take) begin
				res_q <= extra_q;
				res_last_q <= 1'b1;
				extra_v_q <= 1'b0;
			end
		end else if (step) begin
			res_q <= tok0;
			res_v_q <= n_tok != 2'd0;
			res_last_q <= n_tok == 2'd1;
			extra_q <= tok1;
			extra_v_q <= n_tok == 2'd2;
		end else if (out_take) begin
			res_v_q <= 1'b0;
		end
	end

	assign out_valid     = res_v_q;
	assign token_kind    = res_q.kind;
	assign int_value     = res_q.value;
	assign int_saturated = res_q.sat;
	assign id_chars_low  = res_q.lo;
	assign id_chars_high = res_q.hi;
	assign id_length     = res_q.len;
	assign id_truncated  = res_q.trunc;
	assign last_of_run   = res_last_q;

endmodule

@@ src/pl0lex_checker.sv @@
`timescale 1ns / 1ps
module pl0lex_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] token_kind,
	input logic       last_of_run
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind))
		else $error("output word changed under stall");
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_kind <= 6'd32)
		else $error("token kind out of range");
	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && !in_stall) |=> !out_valid)
		else $error("token without a byte");
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid && last_of_run)
		else $error("second token of a byte missing");
endmodule

bind pl0_lexer_token_scanner_top pl0lex_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .token_kind(token_kind),
	.last_of_run(last_of_run)
);
